FILE: design/dxtdec_pkg.sv
// Shared types, codes and arithmetic helpers for the DXT block decoder.
`default_nettype none

package dxtdec_pkg;

    // Block format codes
    localparam logic [1:0] MODE_DXT1 = 2'd0;
    localparam logic [1:0] MODE_DXT3 = 2'd1;
    localparam logic [1:0] MODE_DXT5 = 2'd2;

    // Decoded block queue depth and derived widths
    localparam int QDEPTH = 2;
    localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    // Fully decoded block: palette, alpha table and per-pixel codes
    typedef struct packed {
        logic [1:0]            mode;
        logic [3:0][2:0][7:0]  pal;      // [entry][2=r,1=g,0=b]
        logic [7:0][7:0]       atab;
        logic [31:0]           color_indices;
        logic [63:0]           alpha_bits;
        logic [1:0]            last_col;
        logic [1:0]            last_row;
    } t_entry;

    // Front to queue transfer
    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_q_push;

    // Queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_head;

    // Expand RGB565 to 8-bit channels by bit replication, {r,g,b}
    function automatic logic [2:0][7:0] expand565(input logic [15:0] c);
        logic [2:0][7:0] rgb;
        rgb[2] = {c[15:11], c[15:13]};
        rgb[1] = {c[10:5],  c[10:9]};
        rgb[0] = {c[4:0],   c[4:2]};
        return rgb;
    endfunction

    // x / 3 for x <= 765, by reciprocal 683 / 2^11
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = {10'd0, x} * 20'd683;
        return prod[18:11];
    endfunction

    // x / 7 for x <= 1785, by reciprocal 2341 / 2^14
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [21:0] prod;
        prod = {11'd0, x} * 22'd2341;
        return prod[21:14];
    endfunction

    // x / 5 for x <= 1275, by reciprocal 1639 / 2^13
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [21:0] prod;
        prod = {11'd0, x} * 22'd1639;
        return prod[20:13];
    endfunction

endpackage

`default_nettype wire

FILE: design/dxtdec_front.sv
// Front end: accepts blocks, drops empty and unused-format ones, builds palette and alpha table.
`default_nettype none

module dxtdec_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_mode,
    input  wire logic [15:0]          i_color_end0,
    input  wire logic [15:0]          i_color_end1,
    input  wire logic [31:0]          i_color_indices,
    input  wire logic [63:0]          i_alpha_bits,
    input  wire logic [7:0]           i_alpha_end0,
    input  wire logic [7:0]           i_alpha_end1,
    input  wire logic [2:0]           i_cols_valid,
    input  wire logic [2:0]           i_rows_valid,
    input  wire logic                 i_q_full,
    output dxtdec_pkg::t_q_push       o_q_push
);
    import dxtdec_pkg::*;

    // Sum stage registers
    logic                  r_s1_valid;
    logic [1:0]            r_s1_mode;
    logic                  r_s1_four;
    logic [2:0][7:0]       r_s1_p0, r_s1_p1;
    logic [2:0][9:0]       r_s1_sum21, r_s1_sum12;
    logic [2:0][8:0]       r_s1_sum11;
    logic [7:0]            r_s1_a0, r_s1_a1;
    logic                  r_s1_agt;
    logic [5:0][10:0]      r_s1_asum;
    logic [31:0]           r_s1_idx;
    logic [63:0]           r_s1_abits;
    logic [1:0]            r_s1_lcol, r_s1_lrow;

    logic                  s1_free;
    logic                  accept;
    logic                  item_ok;
    logic [2:0][7:0]       p0, p1;
    logic [2:0][9:0]       n_sum21, n_sum12;
    logic [2:0][8:0]       n_sum11;
    logic [5:0][10:0]      n_asum;
    logic                  a_gt;
    t_entry                entry;

    // Classify the incoming block
    assign s1_free = !r_s1_valid || !i_q_full;
    assign busy    = !s1_free;
    assign accept  = start && !busy;
    assign item_ok = (i_mode == MODE_DXT1 || i_mode == MODE_DXT3 || i_mode == MODE_DXT5)
                     && (i_cols_valid != 3'd0) && (i_rows_valid != 3'd0);

    // Expand endpoints and form interpolation sums
    assign p0   = expand565(i_color_end0);
    assign p1   = expand565(i_color_end1);
    assign a_gt = i_alpha_end0 > i_alpha_end1;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_sum21[ch] = {1'b0, p0[ch], 1'b0} + {2'b0, p1[ch]};
            n_sum12[ch] = {2'b0, p0[ch]} + {1'b0, p1[ch], 1'b0};
            n_sum11[ch] = {1'b0, p0[ch]} + {1'b0, p1[ch]};
        end
        for (int k = 1; k <= 6; k++) begin
            if (a_gt) begin
                n_asum[k-1] = 11'(7 - k) * {3'b0, i_alpha_end0}
                            + 11'(k) * {3'b0, i_alpha_end1};
            end else if (k <= 4) begin
                n_asum[k-1] = 11'(5 - k) * {3'b0, i_alpha_end0}
                            + 11'(k) * {3'b0, i_alpha_end1};
            end else begin
                n_asum[k-1] = '0;
            end
        end
    end

    // Hold the sum stage until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= accept && item_ok;
        end
        if (s1_free && accept) begin
            r_s1_mode  <= i_mode;
            r_s1_four  <= (i_mode != MODE_DXT1) || (i_color_end0 > i_color_end1);
            r_s1_p0    <= p0;
            r_s1_p1    <= p1;
            r_s1_sum21 <= n_sum21;
            r_s1_sum12 <= n_sum12;
            r_s1_sum11 <= n_sum11;
            r_s1_a0    <= i_alpha_end0;
            r_s1_a1    <= i_alpha_end1;
            r_s1_agt   <= a_gt;
            r_s1_asum  <= n_asum;
            r_s1_idx   <= i_color_indices;
            r_s1_abits <= i_alpha_bits;
            r_s1_lcol  <= (i_cols_valid >= 3'd4) ? 2'd3 : 2'(i_cols_valid - 3'd1);
            r_s1_lrow  <= (i_rows_valid >= 3'd4) ? 2'd3 : 2'(i_rows_valid - 3'd1);
        end
    end

    // Divide the sums into palette and alpha table entries
    always_comb begin
        entry.mode          = r_s1_mode;
        entry.color_indices = r_s1_idx;
        entry.alpha_bits    = r_s1_abits;
        entry.last_col      = r_s1_lcol;
        entry.last_row      = r_s1_lrow;
        entry.pal[0]        = r_s1_p0;
        entry.pal[1]        = r_s1_p1;
        for (int ch = 0; ch < 3; ch++) begin
            entry.pal[2][ch] = r_s1_four ? div3(r_s1_sum21[ch]) : r_s1_sum11[ch][8:1];
            entry.pal[3][ch] = r_s1_four ? div3(r_s1_sum12[ch]) : 8'd0;
        end
        entry.atab[0] = r_s1_a0;
        entry.atab[1] = r_s1_a1;
        for (int k = 1; k <= 6; k++) begin
            if (r_s1_agt) begin
                entry.atab[k+1] = div7(r_s1_asum[k-1]);
            end else if (k <= 4) begin
                entry.atab[k+1] = div5(r_s1_asum[k-1]);
            end else if (k == 5) begin
                entry.atab[k+1] = 8'd0;
            end else begin
                entry.atab[k+1] = 8'd255;
            end
        end
    end

    assign o_q_push.push  = r_s1_valid && !i_q_full;
    assign o_q_push.entry = entry;

endmodule

`default_nettype wire

FILE: design/dxtdec_queue.sv
// Short queue of decoded blocks between the front and back ends.
`default_nettype none

module dxtdec_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dxtdec_pkg::t_q_push  i_push,
    input  wire logic                 i_pop,
    output logic                      o_full,
    output dxtdec_pkg::t_q_head       o_head
);
    import dxtdec_pkg::*;

    t_entry             r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full       = (r_count == CNT_W'(QDEPTH));
    assign do_push      = i_push.push && !o_full;
    assign do_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store a pushed block
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.push && o_full))
        else $error("queue push while full");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QDEPTH))
        else $error("queue occupancy out of range");
`endif

endmodule

`default_nettype wire

FILE: design/dxtdec_back.sv
// Back end: walks the valid pixels of the head block and emits one per cycle while a block is queued.
`default_nettype none

module dxtdec_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dxtdec_pkg::t_q_head  i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    output logic [7:0]                o_red,
    output logic [7:0]                o_green,
    output logic [7:0]                o_blue,
    output logic [7:0]                o_alpha,
    output logic [1:0]                o_pixel_col,
    output logic [1:0]                o_pixel_row,
    output logic                      o_last
);
    import dxtdec_pkg::*;

    logic [1:0]  r_col, r_row;
    logic        r_valid, r_last;
    logic [7:0]  r_red, r_green, r_blue, r_alpha;
    logic [1:0]  r_pcol, r_prow;

    t_entry      e;
    logic [3:0]  pix;
    logic [1:0]  ci;
    logic [3:0]  a4;
    logic [5:0]  a3_pos;
    logic [2:0]  ai;
    logic [7:0]  alpha;
    logic        end_col, blk_last;

    // Select the current pixel's codes
    assign e        = i_head.entry;
    assign pix      = {r_row, r_col};
    assign ci       = e.color_indices[{pix, 1'b0} +: 2];
    assign a4       = e.alpha_bits[{pix, 2'b00} +: 4];
    assign a3_pos   = {2'b00, pix} * 6'd3;
    assign ai       = e.alpha_bits[a3_pos +: 3];
    assign end_col  = (r_col == e.last_col);
    assign blk_last = end_col && (r_row == e.last_row);
    assign o_pop    = i_head.valid && blk_last;

    always_comb begin
        unique case (e.mode)
            MODE_DXT3: alpha = {a4, a4};
            MODE_DXT5: alpha = e.atab[ai];
            default:   alpha = 8'd255;
        endcase
    end

    // Step through the block and register the pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_head.valid;
            if (i_head.valid) begin
                if (blk_last) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (end_col) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
        r_red   <= e.pal[ci][2];
        r_green <= e.pal[ci][1];
        r_blue  <= e.pal[ci][0];
        r_alpha <= alpha;
        r_pcol  <= r_col;
        r_prow  <= r_row;
        r_last  <= blk_last;
    end

    assign o_valid     = r_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_alpha     = r_alpha;
    assign o_pixel_col = r_pcol;
    assign o_pixel_row = r_prow;
    assign o_last      = r_valid && r_last;

`ifndef ASSERT_OFF
    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (o_valid && o_last))
        else $error("block pop without last pixel strobe");

    a_head_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head.valid |=> o_valid)
        else $error("pending block did not emit a pixel");
`endif

endmodule

`default_nettype wire

FILE: design/dxt_block_decoder_top.sv
// Top level of the DXT1/DXT3/DXT5 4x4 texture block decoder.
`default_nettype none

// A block is transferred at a clock edge with start high and busy low. Its
// valid pixels come out in row order, one per clock while blocks are queued,
// each shown for exactly one cycle with o_valid high; o_last marks the final
// pixel of the block. The receiver cannot stall the output. A block of C
// columns by R rows occupies the pixel walker until its C*R pixels are out
// (16 for a full block), which sets the sustained rate; the walker moves
// from one block to the next without a gap. The first pixel passes the sum
// stage registers, the queue and the walker's output registers. Blocks of
// the unused format or with zero extent are taken and give no pixels. Up to
// three blocks wait in the decode stage and queue before busy rises.
module dxt_block_decoder_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [1:0]   i_mode,
    input  wire logic [15:0]  i_color_end0,
    input  wire logic [15:0]  i_color_end1,
    input  wire logic [31:0]  i_color_indices,
    input  wire logic [63:0]  i_alpha_bits,
    input  wire logic [7:0]   i_alpha_end0,
    input  wire logic [7:0]   i_alpha_end1,
    input  wire logic [2:0]   i_cols_valid,
    input  wire logic [2:0]   i_rows_valid,
    output logic              o_valid,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [7:0]        o_alpha,
    output logic [1:0]        o_pixel_col,
    output logic [1:0]        o_pixel_row,
    output logic              o_last
);
    import dxtdec_pkg::*;

    t_q_push  q_push;
    t_q_head  q_head;
    logic     q_full;
    logic     q_pop;

    // Decode blocks into palette form
    dxtdec_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_color_end0    (i_color_end0),
        .i_color_end1    (i_color_end1),
        .i_color_indices (i_color_indices),
        .i_alpha_bits    (i_alpha_bits),
        .i_alpha_end0    (i_alpha_end0),
        .i_alpha_end1    (i_alpha_end1),
        .i_cols_valid    (i_cols_valid),
        .i_rows_valid    (i_rows_valid),
        .i_q_full        (q_full),
        .o_q_push        (q_push)
    );

    // Buffer decoded blocks
    dxtdec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    // Emit pixels
    dxtdec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_alpha     (o_alpha),
        .o_pixel_col (o_pixel_col),
        .o_pixel_row (o_pixel_row),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

FILE: test/dxt_block_checker.sv
`timescale 1ns / 1ps
// Pixel checker for the DXT block decoder: decodes each transferred block, compares pixels.
module dxt_block_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic         i_busy,
    input  wire logic [1:0]   i_mode,
    input  wire logic [15:0]  i_color_end0,
    input  wire logic [15:0]  i_color_end1,
    input  wire logic [31:0]  i_color_indices,
    input  wire logic [63:0]  i_alpha_bits,
    input  wire logic [7:0]   i_alpha_end0,
    input  wire logic [7:0]   i_alpha_end1,
    input  wire logic [2:0]   i_cols_valid,
    input  wire logic [2:0]   i_rows_valid,
    input  wire logic         i_valid,
    input  wire logic [7:0]   i_red,
    input  wire logic [7:0]   i_green,
    input  wire logic [7:0]   i_blue,
    input  wire logic [7:0]   i_alpha,
    input  wire logic [1:0]   i_pixel_col,
    input  wire logic [1:0]   i_pixel_row,
    input  wire logic         i_last,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_pixel_count
);

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] col;
        logic [1:0] row;
        logic       last;
    } t_rgba_pixel;

    t_rgba_pixel decoded_pixels[$];
    t_rgba_pixel want;
    int          fail_count  = 0;
    int          pixel_count = 0;

    assign o_fail_count  = fail_count;
    assign o_pending     = decoded_pixels.size();
    assign o_pixel_count = pixel_count;

    // Widen a 5- or 6-bit channel to 8 bits by repeating its top bits
    function automatic int widen(input int v, input int bits);
        return ((v << (8 - bits)) | (v >> (2 * bits - 8))) & 8'hFF;
    endfunction

    // Decode one block into the pixels it must produce, in row order
    task automatic decode_block(input logic [1:0] mode, input logic [15:0] e0,
                                input logic [15:0] e1, input logic [31:0] idx,
                                input logic [63:0] abits, input logic [7:0] a0,
                                input logic [7:0] a1, input logic [2:0] cols_in,
                                input logic [2:0] rows_in);
        int          pal[4][3];
        int          atab[8];
        int          ia0;
        int          ia1;
        int          cols;
        int          rows;
        int          ch;
        int          k;
        int          r;
        int          c;
        int          p;
        int          ci;
        int          av;
        int          total;
        int          n;
        bit          four_color;
        t_rgba_pixel px;

        // Drop the unused format and clamp the extent
        if (mode > dxtdec_pkg::MODE_DXT5) return;
        cols = (cols_in > 3'd4) ? 4 : int'(cols_in);
        rows = (rows_in > 3'd4) ? 4 : int'(rows_in);
        if (cols == 0 || rows == 0) return;

        // Colour palette
        pal[0][0] = widen(int'(e0[15:11]), 5);
        pal[0][1] = widen(int'(e0[10:5]), 6);
        pal[0][2] = widen(int'(e0[4:0]), 5);
        pal[1][0] = widen(int'(e1[15:11]), 5);
        pal[1][1] = widen(int'(e1[10:5]), 6);
        pal[1][2] = widen(int'(e1[4:0]), 5);
        four_color = (mode != dxtdec_pkg::MODE_DXT1) || (e0 > e1);
        for (ch = 0; ch < 3; ch++) begin
            if (four_color) begin
                pal[2][ch] = (2 * pal[0][ch] + pal[1][ch]) / 3;
                pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch]) / 3;
            end else begin
                pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
                pal[3][ch] = 0;
            end
        end

        // Interpolated alpha table, six steps or four plus the two extremes
        ia0 = int'(a0);
        ia1 = int'(a1);
        atab[0] = ia0;
        atab[1] = ia1;
        if (ia0 > ia1) begin
            for (k = 1; k <= 6; k++) atab[k + 1] = ((7 - k) * ia0 + k * ia1) / 7;
        end else begin
            for (k = 1; k <= 4; k++) atab[k + 1] = ((5 - k) * ia0 + k * ia1) / 5;
            atab[6] = 0;
            atab[7] = 255;
        end

        // Walk the valid pixels
        total = rows * cols;
        n = 0;
        for (r = 0; r < rows; r++) begin
            for (c = 0; c < cols; c++) begin
                p  = r * 4 + c;
                ci = int'((idx >> (2 * p)) & 32'h3);
                case (mode)
                    dxtdec_pkg::MODE_DXT1: av = 255;
                    dxtdec_pkg::MODE_DXT3: av = int'((abits >> (4 * p)) & 64'hF) * 17;
                    default:               av = atab[int'((abits >> (3 * p)) & 64'h7)];
                endcase
                px.red   = 8'(pal[ci][0]);
                px.green = 8'(pal[ci][1]);
                px.blue  = 8'(pal[ci][2]);
                px.alpha = 8'(av);
                px.col   = 2'(c);
                px.row   = 2'(r);
                px.last  = (n + 1 == total);
                decoded_pixels.push_back(px);
                n++;
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Capture block transfers and compare pixels against the oldest decoded one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            decoded_pixels.delete();
        end else begin
            if (i_start && !i_busy) begin
                decode_block(i_mode, i_color_end0, i_color_end1, i_color_indices,
                             i_alpha_bits, i_alpha_end0, i_alpha_end1,
                             i_cols_valid, i_rows_valid);
            end
            if (i_valid) begin
                if (decoded_pixels.size() == 0) begin
                    $error("pixel at col %0d row %0d with none expected",
                           i_pixel_col, i_pixel_row);
                    fail_count++;
                end else begin
                    want = decoded_pixels.pop_front();
                    pixel_count++;
                    check_field("red", want.red, i_red);
                    check_field("green", want.green, i_green);
                    check_field("blue", want.blue, i_blue);
                    check_field("alpha", want.alpha, i_alpha);
                    check_field("pixel_col", 8'(want.col), 8'(i_pixel_col));
                    check_field("pixel_row", 8'(want.row), 8'(i_pixel_row));
                    check_field("last", 8'(want.last), 8'(i_last));
                end
            end
        end
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench top for the DXT block decoder: clock, reset, block stimulus and verdict.
module tb;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         RANDOM_BLOCKS = 80;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         DRAIN_CYCLES  = 8;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    logic [1:0]   i_mode = '0;
    logic [15:0]  i_color_end0 = '0;
    logic [15:0]  i_color_end1 = '0;
    logic [31:0]  i_color_indices = '0;
    logic [63:0]  i_alpha_bits = '0;
    logic [7:0]   i_alpha_end0 = '0;
    logic [7:0]   i_alpha_end1 = '0;
    logic [2:0]   i_cols_valid = 3'd1;
    logic [2:0]   i_rows_valid = 3'd1;
    logic         o_valid;
    logic [7:0]   o_red;
    logic [7:0]   o_green;
    logic [7:0]   o_blue;
    logic [7:0]   o_alpha;
    logic [1:0]   o_pixel_col;
    logic [1:0]   o_pixel_row;
    logic         o_last;

    int           fail_count;
    int           pending;
    int           pixel_count;
    int           stall_cycles = 0;
    int           idle_pct = 0;
    int           decoded_blocks = 0;
    int           empty_blocks = 0;
    int           mode_blocks[3] = '{0, 0, 0};
    int           rand_start;
    int           done;
    int           p;
    bit           paused;
    logic [63:0]  dxt5_ramp;

    always #5 i_clk = ~i_clk;

    dxt_block_decoder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_color_end0    (i_color_end0),
        .i_color_end1    (i_color_end1),
        .i_color_indices (i_color_indices),
        .i_alpha_bits    (i_alpha_bits),
        .i_alpha_end0    (i_alpha_end0),
        .i_alpha_end1    (i_alpha_end1),
        .i_cols_valid    (i_cols_valid),
        .i_rows_valid    (i_rows_valid),
        .o_valid         (o_valid),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_alpha         (o_alpha),
        .o_pixel_col     (o_pixel_col),
        .o_pixel_row     (o_pixel_row),
        .o_last          (o_last)
    );

    dxt_block_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_mode          (i_mode),
        .i_color_end0    (i_color_end0),
        .i_color_end1    (i_color_end1),
        .i_color_indices (i_color_indices),
        .i_alpha_bits    (i_alpha_bits),
        .i_alpha_end0    (i_alpha_end0),
        .i_alpha_end1    (i_alpha_end1),
        .i_cols_valid    (i_cols_valid),
        .i_rows_valid    (i_rows_valid),
        .i_valid         (o_valid),
        .i_red           (o_red),
        .i_green         (o_green),
        .i_blue          (o_blue),
        .i_alpha         (o_alpha),
        .i_pixel_col     (o_pixel_col),
        .i_pixel_row     (o_pixel_row),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_pixel_count   (pixel_count)
    );

    // Abort when neither a block transfer nor a pixel happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one block, idling first at the current rate; return at its transfer edge
    task automatic send_block(input logic [1:0] mode, input logic [15:0] e0,
                              input logic [15:0] e1, input logic [31:0] idx,
                              input logic [63:0] abits, input logic [7:0] a0,
                              input logic [7:0] a1, input logic [2:0] cols,
                              input logic [2:0] rows);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_mode          <= mode;
        i_color_end0    <= e0;
        i_color_end1    <= e1;
        i_color_indices <= idx;
        i_alpha_bits    <= abits;
        i_alpha_end0    <= a0;
        i_alpha_end1    <= a1;
        i_cols_valid    <= cols;
        i_rows_valid    <= rows;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (mode == MODE_UNUSED || cols == 3'd0 || rows == 3'd0) begin
            empty_blocks++;
        end else begin
            decoded_blocks++;
            mode_blocks[mode]++;
        end
    endtask

    // Hold off until every decoded pixel has come out, then let the pipe settle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed blocks with random content, a few unused or empty ones
    task automatic send_random_block();
        logic [1:0]  mode;
        logic [15:0] e0;
        logic [15:0] e1;
        logic [7:0]  a0;
        logic [7:0]  a1;
        logic [2:0]  cols;
        logic [2:0]  rows;
        mode = ($urandom_range(99) < 4) ? MODE_UNUSED : 2'($urandom_range(2));
        e0   = 16'($urandom);
        e1   = ($urandom_range(9) == 0) ? e0 : 16'($urandom);
        a0   = 8'($urandom);
        a1   = ($urandom_range(7) == 0) ? a0 : 8'($urandom);
        cols = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
        rows = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
        send_block(mode, e0, e1, $urandom, {$urandom, $urandom}, a0, a1, cols, rows);
    endtask

    initial begin
        // DXT5 indices 0..7 twice over, upper 16 bits set so they must be ignored
        dxt5_ramp = 64'hFFFF_0000_0000_0000;
        for (p = 0; p < 16; p++) dxt5_ramp |= 64'(p % 8) << (3 * p);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: palette modes, alpha schemes, extents and corner values
        idle_pct = 17;
        send_block(dxtdec_pkg::MODE_DXT1, 16'hF800, 16'h001F, 32'hE4E4E4E4, '1,
                   8'h00, 8'hFF, 3'd4, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT1, 16'h001F, 16'hF800, 32'hE4E4E4E4, '1,
                   8'hFF, 8'h00, 3'd4, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT1, 16'h7BEF, 16'h7BEF, 32'hFFFFFFFF, '0,
                   8'h00, 8'h00, 3'd4, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT1, 16'hFFFF, 16'h0000, 32'h1B1B1B1B, '0,
                   8'h00, 8'h00, 3'd4, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT1, 16'h07E0, 16'h0000, 32'hE4E4E4E4, '0,
                   8'h00, 8'h00, 3'd4, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT3, 16'h0000, 16'hFFFF, 32'hE4E4E4E4,
                   64'h0123456789ABCDEF, 8'hFF, 8'h00, 3'd4, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT3, 16'h0001, 16'h0000, 32'h00000000,
                   64'hFEDCBA9876543210, 8'h00, 8'hFF, 3'd4, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT3, 16'h0000, 16'h0000, 32'h00000000, '0,
                   8'h00, 8'h00, 3'd4, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT5, 16'hF800, 16'h07E0, 32'h1B1B1B1B, dxt5_ramp,
                   8'd200, 8'd10, 3'd4, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT5, 16'h07E0, 16'hF800, 32'hE4E4E4E4, dxt5_ramp,
                   8'd10, 8'd200, 3'd4, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT5, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, dxt5_ramp,
                   8'd128, 8'd128, 3'd4, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT5, 16'h0000, 16'hFFFF, 32'hAAAAAAAA, dxt5_ramp,
                   8'd255, 8'd0, 3'd4, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT5, 16'hFFFF, 16'h0000, 32'h55555555, dxt5_ramp,
                   8'd0, 8'd255, 3'd4, 3'd4);
        // Unused format and zero extent give no pixels
        send_block(MODE_UNUSED, 16'hF800, 16'h001F, 32'hE4E4E4E4, '1,
                   8'hFF, 8'h00, 3'd4, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT1, 16'hF800, 16'h001F, 32'hE4E4E4E4, '0,
                   8'h00, 8'h00, 3'd0, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT3, 16'hF800, 16'h001F, 32'hE4E4E4E4, '1,
                   8'h00, 8'h00, 3'd4, 3'd0);
        // Oversized extent clamps to the full block
        send_block(dxtdec_pkg::MODE_DXT5, 16'h1234, 16'hABCD, 32'h9C3E71A5, dxt5_ramp,
                   8'd77, 8'd33, 3'd7, 3'd5);
        send_block(dxtdec_pkg::MODE_DXT3, 16'hABCD, 16'h1234, 32'h3E71A59C,
                   64'hA5A5A5A55A5A5A5A, 8'd0, 8'd0, 3'd5, 3'd6);
        // Partial blocks at the image edge
        send_block(dxtdec_pkg::MODE_DXT1, 16'h8410, 16'h4208, 32'h00000003, '0,
                   8'h00, 8'h00, 3'd1, 3'd1);
        send_block(dxtdec_pkg::MODE_DXT3, 16'h4208, 16'h8410, 32'h000000E4,
                   64'h000000000000F0A5, 8'h00, 8'h00, 3'd4, 3'd1);
        send_block(dxtdec_pkg::MODE_DXT5, 16'hC618, 16'h39E7, 32'h03020100, dxt5_ramp,
                   8'd5, 8'd250, 3'd1, 3'd4);
        send_block(dxtdec_pkg::MODE_DXT1, 16'h39E7, 16'hC618, 32'h00E400E4, '0,
                   8'h00, 8'h00, 3'd3, 3'd2);

        // Wait for the directed pixels before going random
        drain();

        // Random blocks over three idle profiles, with one full pause midway
        rand_start = decoded_blocks;
        paused     = 1'b0;
        while (decoded_blocks - rand_start < RANDOM_BLOCKS) begin
            done     = decoded_blocks - rand_start;
            idle_pct = (done < RANDOM_BLOCKS / 3) ? 17 :
                       (done < 2 * RANDOM_BLOCKS / 3) ? 61 : 0;
            if (!paused && done == RANDOM_BLOCKS / 2) begin
                drain();
                paused = 1'b1;
            end
            send_random_block();
        end

        drain();

        $display("Decoded %0d blocks (DXT1 %0d, DXT3 %0d, DXT5 %0d), %0d skipped as empty",
                 decoded_blocks, mode_blocks[0], mode_blocks[1], mode_blocks[2],
                 empty_blocks);
        $display("Compared %0d pixels under light, heavy and no sender idling",
                 pixel_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
